// ===== rtl/lbc_pkg.sv =====
package lbc_pkg;

    localparam int KEY_W    = 64;
    localparam int SIZE_W   = 21;
    localparam int CAP_W    = 25;
    localparam int ESLOT_W  = 4;
    localparam int EVICT_W  = 5;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_TOO_BIG  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_SLOT  = 3'd5;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd6;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MAX_OBJ  = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 25'd1048576;
    localparam logic [SIZE_W-1:0] MAX_OBJ_RESET = 21'd102400;

endpackage

// ===== rtl/lru_byte_budget_cache_directory_core.sv =====
// Release, too-big and the unused request code go straight to the result. A lookup
// miss and a duplicate insert take a tag scan, then the result; a lookup hit runs tag scan,
// rank scan, rank fix, result. Insert: tag scan, budget check, then per eviction a victim
// scan, rank scan and budget check, a victim scan that finds nothing if one is run, the
// free-slot scan if a slot is needed, then the result. One item at a time, next once the result goes.
// Async active-low reset: all slots invalid, byte count zero, registers default.
module lru_byte_budget_cache_directory_core
    import lbc_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int PIN_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key_tag[63:0], obj_size[84:64], entry_slot[88:85]
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot[3:0], evicted_count[8:4], used_bytes[33:9],
                                   // over_budget[34]
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [24:0] cfg_wdata
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int BYTES_W = SIZE_W + SLOT_W + 1;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAG   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_VICT  = 3'd3;
    localparam logic [2:0] S_CLOSE = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_FIX   = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]          state_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [SIZE_W-1:0]   maxobj_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [KEY_W-1:0]    tag_mem  [SLOTS];
    logic [SIZE_W-1:0]   size_mem [SLOTS];
    logic [PIN_BITS-1:0] pin_mem  [SLOTS];
    logic [SLOT_W-1:0]   rank_mem [SLOTS];
    logic [CNT_W-1:0]    cnt_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic                lookup_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SIZE_W-1:0]   osize_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   tgt_reg;
    logic [SLOT_W-1:0]   close_r_reg;
    logic                bv_reg;
    logic [SLOT_W-1:0]   best_reg;
    logic [SLOT_W-1:0]   best_rank_reg;
    logic [SIZE_W-1:0]   best_size_reg;
    logic [CNT_W-1:0]    ev_reg;
    logic [STAT_W-1:0]   res_st_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;
    logic [2:0]          m_tuser_reg;

    logic [KEY_W-1:0]    in_key;
    logic [SIZE_W-1:0]   in_size;
    logic [ESLOT_W-1:0]  in_es;
    logic [SLOT_W-1:0]   es_idx;
    logic                es_ok;
    logic [SLOT_W-1:0]   addr;
    logic                idx_last;
    logic                cur_valid;
    logic [PIN_BITS-1:0] cur_pin;
    logic [SLOT_W-1:0]   cur_rank;
    logic                cand;
    logic                need;
    logic                in_xfer;
    logic [BYTES_W:0]    sum_bytes;

    assign in_key  = s_tdata[63:0];
    assign in_size = s_tdata[84:64];
    assign in_es   = s_tdata[88:85];
    assign es_idx  = SLOT_W'(in_es);
    assign es_ok   = 32'(in_es) < SLOTS;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // single read port into the slot table
    assign addr      = (state_reg == S_IDLE) ? es_idx : idx_reg;
    assign idx_last  = (32'(idx_reg) == SLOTS - 1);
    assign cur_valid = valid_reg[addr];
    assign cur_pin   = pin_mem[addr];
    assign cur_rank  = rank_mem[addr];
    assign cand      = cur_valid && (cur_pin == '0) && (!bv_reg || cur_rank < best_rank_reg);
    assign sum_bytes = (BYTES_W+1)'(osize_reg) + (BYTES_W+1)'(bytes_reg);
    assign need      = (sum_bytes > (BYTES_W+1)'(cap_reg)) || (32'(cnt_reg) == SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            maxobj_reg <= MAX_OBJ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CAPACITY: cap_reg    <= cfg_wdata;
                REG_MAX_OBJ:  maxobj_reg <= cfg_wdata[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_xfer && s_tuser == REQ_RELEASE && es_ok
            && cur_valid && cur_pin != '0)
            pin_mem[es_idx] <= cur_pin - 1'b1;
        if (state_reg == S_TAG && lookup_reg && cur_valid && tag_mem[idx_reg] == key_reg
            && cur_pin != PIN_MAX)
            pin_mem[idx_reg] <= cur_pin + 1'b1;
        if (state_reg == S_CLOSE && cur_valid && cur_rank > close_r_reg)
            rank_mem[idx_reg] <= cur_rank - 1'b1;
        if (state_reg == S_FIX)
            rank_mem[tgt_reg] <= SLOT_W'(cnt_reg - 1'b1);
        if (state_reg == S_FREE && !cur_valid)
        begin
            tag_mem[idx_reg]  <= key_reg;
            size_mem[idx_reg] <= osize_reg;
            pin_mem[idx_reg]  <= '0;
            rank_mem[idx_reg] <= SLOT_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            bytes_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            bv_reg       <= 1'b0;
            ev_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_RESP)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        key_reg      <= in_key;
                        osize_reg    <= in_size;
                        lookup_reg   <= (s_tuser == REQ_LOOKUP);
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        ev_reg       <= '0;
                        res_slot_reg <= '0;
                        priority if (s_tuser == REQ_LOOKUP)
                            state_reg <= S_TAG;
                        else if (s_tuser == REQ_INSERT)
                        begin
                            if (in_size > maxobj_reg)
                            begin
                                res_st_reg <= ST_TOO_BIG;
                                state_reg  <= S_RESP;
                            end
                            else
                                state_reg <= S_TAG;
                        end
                        else if (s_tuser == REQ_RELEASE)
                        begin
                            res_st_reg <= ST_RELEASED;
                            state_reg  <= S_RESP;
                        end
                        else
                        begin
                            res_st_reg <= ST_MISS;
                            state_reg  <= S_RESP;
                        end
                    end
                end
                S_TAG:
                begin
                    if (cur_valid && tag_mem[idx_reg] == key_reg)
                    begin
                        found_reg   <= 1'b1;
                        tgt_reg     <= idx_reg;
                        close_r_reg <= cur_rank;
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (idx_last)
                    begin
                        if (found_reg || (cur_valid && tag_mem[idx_reg] == key_reg))
                        begin
                            if (lookup_reg)
                                state_reg <= S_CLOSE;
                            else
                            begin
                                res_st_reg <= ST_DUP;
                                state_reg  <= S_RESP;
                            end
                        end
                        else if (lookup_reg)
                        begin
                            res_st_reg <= ST_MISS;
                            state_reg  <= S_RESP;
                        end
                        else
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    idx_reg <= '0;
                    bv_reg  <= 1'b0;
                    state_reg <= need ? S_VICT : S_FREE;
                end
                S_VICT:
                begin
                    if (cand)
                    begin
                        bv_reg        <= 1'b1;
                        best_reg      <= idx_reg;
                        best_rank_reg <= cur_rank;
                        best_size_reg <= size_mem[idx_reg];
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (idx_last)
                    begin
                        if (cand || bv_reg)
                        begin
                            // evict the least recent unpinned entry
                            valid_reg[cand ? idx_reg : best_reg] <= 1'b0;
                            bytes_reg <= bytes_reg
                                - BYTES_W'(cand ? size_mem[idx_reg] : best_size_reg);
                            close_r_reg <= cand ? cur_rank : best_rank_reg;
                            cnt_reg   <= cnt_reg - 1'b1;
                            ev_reg    <= ev_reg + 1'b1;
                            state_reg <= S_CLOSE;
                        end
                        else if (32'(cnt_reg) == SLOTS)
                        begin
                            res_st_reg <= ST_NO_SLOT;
                            state_reg  <= S_RESP;
                        end
                        else
                            state_reg <= S_FREE;
                    end
                end
                S_CLOSE:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (idx_last)
                        state_reg <= lookup_reg ? S_FIX : S_CHECK;
                end
                S_FIX:
                begin
                    res_st_reg   <= ST_HIT;
                    res_slot_reg <= tgt_reg;
                    state_reg    <= S_RESP;
                end
                S_FREE:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!cur_valid)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        cnt_reg      <= cnt_reg + 1'b1;
                        bytes_reg    <= bytes_reg + BYTES_W'(osize_reg);
                        res_st_reg   <= ST_INSERTED;
                        res_slot_reg <= idx_reg;
                        state_reg    <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP)
        begin
            m_tuser_reg <= res_st_reg;
            m_tdata_reg <= {5'd0,
                            bytes_reg > BYTES_W'(cap_reg),
                            (bytes_reg > BYTES_W'({CAP_W{1'b1}}))
                                ? {CAP_W{1'b1}} : CAP_W'(bytes_reg),
                            (32'(ev_reg) > 31) ? 5'd31 : EVICT_W'(ev_reg),
                            ESLOT_W'(res_slot_reg)};
        end
    end

`ifndef ASSERT_OFF
    a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(valid_reg))
        else $error("slot count out of step with valid bits");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (bytes_reg == '0))
        else $error("bytes held with no valid slot");
    a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |-> !m_tvalid_reg)
        else $error("result register still occupied");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not presented");
`endif

endmodule
